>>> rtl/modular_exponentiation_core_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the modular exponentiation core
// Clocked on clock, disabled while reset is high.
// ---------------------------------------------------------------------------
`ifndef MODULAR_EXPONENTIATION_CORE_MACROS_SVH
`define MODULAR_EXPONENTIATION_CORE_MACROS_SVH

// property must hold at every edge outside reset
`define MEXP_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// expression must never be true outside reset
`define MEXP_NEVER(lbl, expr, msg) \
   `MEXP_ASSERT(lbl, !(expr), msg)

`endif

>>> rtl/mexp_pkg.sv
// ---------------------------------------------------------------------------
// mexp_pkg
// Widths, constants and the request/response types of the shared
// modular multiplier.
// ---------------------------------------------------------------------------
`default_nettype none

package mexp_pkg;

   localparam int OPERAND_WIDTH = 32;                  // 8..32
   localparam int DATA_WIDTH    = 32;                  // port width
   localparam int CNT_W         = $clog2(OPERAND_WIDTH);
   localparam int EXT_W         = OPERAND_WIDTH + 2;   // holds 2r + x < 3m

   localparam logic [DATA_WIDTH-1:0] MODULUS_RESET = DATA_WIDTH'(2);

   typedef logic [OPERAND_WIDTH-1:0] opnd_type;

   localparam opnd_type OPND_ONE = OPERAND_WIDTH'(1);
   localparam opnd_type OPND_MIN = OPERAND_WIDTH'(2);

   typedef struct packed {
      logic     start;
      opnd_type x;       // must be below the modulus
      opnd_type y;
   } mul_req_type;

   typedef struct packed {
      logic     busy;
      logic     done;
      opnd_type prod;    // x * y mod m, valid with done
   } mul_rsp_type;

endpackage

`default_nettype wire

>>> rtl/mexp_mulmod.sv
// ---------------------------------------------------------------------------
// mexp_mulmod
// Bit-serial interleaved modular multiplier: one multiplier bit per cycle,
// MSB first, r = 2r + y_bit*x reduced into [0, m) by one or two m.
// ---------------------------------------------------------------------------
`default_nettype none

`include "modular_exponentiation_core_macros.svh"

module mexp_mulmod (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire mexp_pkg::opnd_type    m,
   input  wire mexp_pkg::mul_req_type mul_req,
   output mexp_pkg::mul_rsp_type      mul_rsp
);
   import mexp_pkg::*;

   opnd_type         r_ff, r_in;
   opnd_type         x_ff, x_in;
   opnd_type         y_ff, y_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;

   logic [EXT_W-1:0] sum;
   logic [EXT_W-1:0] m1;
   logic [EXT_W-1:0] m2;
   logic [EXT_W-1:0] red;

   always_comb begin
      m1  = EXT_W'(m);
      m2  = {1'b0, m, 1'b0};
      sum = {1'b0, r_ff, 1'b0} + (y_ff[OPERAND_WIDTH-1] ? EXT_W'(x_ff) : EXT_W'(0));
      priority if (sum >= m2) begin
         red = sum - m2;
      end else if (sum >= m1) begin
         red = sum - m1;
      end else begin
         red = sum;
      end
   end

   always_comb begin
      r_in    = r_ff;
      x_in    = x_ff;
      y_in    = y_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (busy_ff) begin
         r_in = red[OPERAND_WIDTH-1:0];
         y_in = {y_ff[OPERAND_WIDTH-2:0], 1'b0};
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff - CNT_W'(1);
         end
      end else if (mul_req.start) begin
         r_in    = '0;
         x_in    = mul_req.x;
         y_in    = mul_req.y;
         cnt_in  = CNT_W'(OPERAND_WIDTH - 1);
         busy_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      r_ff   <= r_in;
      x_ff   <= x_in;
      y_ff   <= y_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign mul_rsp.busy = busy_ff;
   assign mul_rsp.done = done_ff;
   assign mul_rsp.prod = r_ff;

   `MEXP_NEVER(a_start_while_busy, mul_req.start && busy_ff, "mulmod started while busy")
   `MEXP_ASSERT(a_done_ends_run, done_ff |-> ($past(busy_ff) && !busy_ff), "stray done")
   `MEXP_ASSERT(a_rem_in_range, (busy_ff || done_ff) |-> (r_ff < m), "remainder not below m")

endmodule

`default_nettype wire

>>> rtl/modular_exponentiation_core.sv
// ---------------------------------------------------------------------------
// modular_exponentiation_core
// base^exponent mod modulus by left-to-right square-and-multiply over one
// shared bit-serial modular multiplier.
//
//   channel  ports                          flow
//   req      start, busy, req_*             in at start && !busy
//   rsp      rsp_valid, rsp_power_result    out, one-cycle strobe
//   csr      csr_valid, csr_ready, csr_*    in at csr_valid && csr_ready
//
// Each modular multiplication runs in the shared multiplier. An item
// costs one reduction of base plus, per exponent bit, one square and
// one multiply when the bit is set. Exponent zero answers in the next
// cycle and leaves busy low. Otherwise busy is high from acceptance
// until the result strobe. Synchronous reset sets the modulus to 2 and
// aborts any item. The receiver cannot stall.
// ---------------------------------------------------------------------------
`default_nettype none

`include "modular_exponentiation_core_macros.svh"

module modular_exponentiation_core (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            start,
   output logic                                 busy,
   input  wire logic [mexp_pkg::DATA_WIDTH-1:0] req_base,
   input  wire logic [mexp_pkg::DATA_WIDTH-1:0] req_exponent,
   output logic                                 rsp_valid,
   output logic [mexp_pkg::DATA_WIDTH-1:0]      rsp_power_result,
   input  wire logic                            csr_valid,
   output logic                                 csr_ready,
   input  wire logic [mexp_pkg::DATA_WIDTH-1:0] csr_modulus
);
   import mexp_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_REDUCE,
      ST_SQUARE,
      ST_MULTIPLY
   } state_type;

   state_type               state_ff, state_in;
   logic [DATA_WIDTH-1:0]   modulus_ff, modulus_in;
   opnd_type                m_ff, m_in;
   opnd_type                b_ff, b_in;
   opnd_type                e_ff, e_in;
   opnd_type                acc_ff, acc_in;
   logic [CNT_W-1:0]        cnt_ff, cnt_in;
   mul_req_type             mul_req_ff, mul_req_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [DATA_WIDTH-1:0]   rsp_power_result_ff, rsp_power_result_in;

   mul_rsp_type             mul_rsp;
   opnd_type                m_eff;
   opnd_type                exp_in;
   logic                    bit_done;

   mexp_mulmod u_mulmod (
      .clock   (clock),
      .reset   (reset),
      .m       (m_ff),
      .mul_req (mul_req_ff),
      .mul_rsp (mul_rsp)
   );

   // moduli 0 and 1 act as 2
   always_comb begin
      m_eff = modulus_ff[OPERAND_WIDTH-1:0];
      if (m_eff < OPND_MIN) begin
         m_eff = OPND_MIN;
      end
   end

   assign exp_in = req_exponent[OPERAND_WIDTH-1:0];

   always_comb begin
      state_in            = state_ff;
      modulus_in          = modulus_ff;
      m_in                = m_ff;
      b_in                = b_ff;
      e_in                = e_ff;
      acc_in              = acc_ff;
      cnt_in              = cnt_ff;
      mul_req_in          = mul_req_ff;
      mul_req_in.start    = 1'b0;
      rsp_valid_in        = 1'b0;
      rsp_power_result_in = rsp_power_result_ff;
      bit_done            = 1'b0;

      if (csr_valid && csr_ready) begin
         modulus_in = csr_modulus;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               m_in   = m_eff;
               e_in   = exp_in;
               acc_in = OPND_ONE;
               cnt_in = CNT_W'(OPERAND_WIDTH - 1);
               if (exp_in == '0) begin
                  rsp_valid_in        = 1'b1;
                  rsp_power_result_in = DATA_WIDTH'(1);
               end else begin
                  // base mod m as 1 * base mod m
                  mul_req_in = '{start: 1'b1, x: OPND_ONE,
                                 y: req_base[OPERAND_WIDTH-1:0]};
                  state_in   = ST_REDUCE;
               end
            end
         end
         ST_REDUCE: begin
            if (mul_rsp.done) begin
               b_in       = mul_rsp.prod;
               mul_req_in = '{start: 1'b1, x: acc_ff, y: acc_ff};
               state_in   = ST_SQUARE;
            end
         end
         ST_SQUARE: begin
            if (mul_rsp.done) begin
               acc_in = mul_rsp.prod;
               if (e_ff[OPERAND_WIDTH-1]) begin
                  mul_req_in = '{start: 1'b1, x: mul_rsp.prod, y: b_ff};
                  state_in   = ST_MULTIPLY;
               end else begin
                  bit_done = 1'b1;
               end
            end
         end
         ST_MULTIPLY: begin
            if (mul_rsp.done) begin
               acc_in   = mul_rsp.prod;
               bit_done = 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (bit_done) begin
         if (cnt_ff == '0) begin
            rsp_valid_in        = 1'b1;
            rsp_power_result_in = DATA_WIDTH'(mul_rsp.prod);
            state_in            = ST_IDLE;
         end else begin
            cnt_in     = cnt_ff - CNT_W'(1);
            e_in       = {e_ff[OPERAND_WIDTH-2:0], 1'b0};
            mul_req_in = '{start: 1'b1, x: mul_rsp.prod, y: mul_rsp.prod};
            state_in   = ST_SQUARE;
         end
      end
   end

   always_ff @(posedge clock) begin
      m_ff                <= m_in;
      b_ff                <= b_in;
      e_ff                <= e_in;
      acc_ff              <= acc_in;
      cnt_ff              <= cnt_in;
      mul_req_ff.x        <= mul_req_in.x;
      mul_req_ff.y        <= mul_req_in.y;
      rsp_power_result_ff <= rsp_power_result_in;
      if (reset) begin
         state_ff         <= ST_IDLE;
         modulus_ff       <= MODULUS_RESET;
         mul_req_ff.start <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         state_ff         <= state_in;
         modulus_ff       <= modulus_in;
         mul_req_ff.start <= mul_req_in.start;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   assign busy             = (state_ff != ST_IDLE);
   assign csr_ready        = (state_ff == ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_power_result = rsp_power_result_ff;

   `MEXP_ASSERT(a_rsp_when_idle, rsp_valid_ff |-> (state_ff == ST_IDLE), "result while busy")
   `MEXP_ASSERT(a_rsp_in_range, rsp_valid |-> (rsp_power_result < DATA_WIDTH'(m_ff)), "bad result")
   `MEXP_ASSERT(a_accept_acts, (start && !busy) |=> (busy || rsp_valid_ff), "beat dropped")
   `MEXP_NEVER(a_mul_idle_fsm, (state_ff == ST_IDLE) && mul_rsp.busy, "multiplier busy at idle")

endmodule

`default_nettype wire

>>> verif/tb_modular_exponentiation_core.sv
// ---------------------------------------------------------------------------
// tb_modular_exponentiation_core
// Self-checking bench for the modular exponentiation core. A scoreboard
// computes base^exponent mod modulus for every accepted request and
// compares each response strobe against the oldest pending power. The
// modulus register is rewritten between bursts once the core has drained.
// ---------------------------------------------------------------------------
`default_nettype none

module tb_modular_exponentiation_core;
   import mexp_pkg::*;

   typedef logic [DATA_WIDTH-1:0] word_type;

   localparam int CYCLE_LIMIT     = 4_000_000;
   localparam int TAIL_CYCLES     = 40;
   localparam int SETTLE_CYCLES   = 4;
   localparam int SENDER_IDLE_PCT = 60;
   localparam int BOTH_IDLE_PCT   = 7;
   localparam int PHASE_COUNT     = 6;
   localparam int PHASE_ITEMS     = 42;

   class power_scoreboard;
      word_type modulus;
      word_type expected_powers[$];
      int       error_count;

      function new();
         modulus     = MODULUS_RESET;
         error_count = 0;
      endfunction

      function word_type predict_power(word_type base, word_type exponent);
         logic [63:0] mask;
         logic [63:0] m;
         logic [63:0] b;
         logic [63:0] acc;
         mask = (64'd1 << OPERAND_WIDTH) - 64'd1;
         m    = 64'(modulus) & mask;
         if (m < 64'd2) m = 64'd2;
         b   = (64'(base) & mask) % m;
         acc = 64'd1;
         if ((64'(exponent) & mask) == 64'd0) return word_type'(1);
         for (int i = OPERAND_WIDTH - 1; i >= 0; i--) begin
            acc = (acc * acc) % m;
            if (exponent[i]) acc = (acc * b) % m;
         end
         return word_type'(acc);
      endfunction

      function void note_request(word_type base, word_type exponent);
         expected_powers.push_back(predict_power(base, exponent));
      endfunction

      function void check_power(word_type got);
         word_type want;
         if (expected_powers.size() == 0) begin
            $error("power_result: unexpected beat, expected none, actual %0h", got);
            error_count++;
         end else begin
            want = expected_powers.pop_front();
            if (got !== want) begin
               $error("power_result: expected %0h, actual %0h", want, got);
               error_count++;
            end
         end
      endfunction

      function int pending();
         return expected_powers.size();
      endfunction
   endclass

   logic     clock;
   logic     reset;
   logic     start;
   logic     busy;
   word_type req_base;
   word_type req_exponent;
   logic     rsp_valid;
   word_type rsp_power_result;
   logic     csr_valid;
   logic     csr_ready;
   word_type csr_modulus;

   power_scoreboard powers;
   int              idle_pct;
   int              cycle_count = 0;

   modular_exponentiation_core dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_base         (req_base),
      .req_exponent     (req_exponent),
      .rsp_valid        (rsp_valid),
      .rsp_power_result (rsp_power_result),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_modulus      (csr_modulus)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid) powers.check_power(rsp_power_result);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // mostly short geometric gaps; now and then a long one so start drops
   // at an arbitrary point of the multiply schedule
   function automatic int draw_gap(int pct);
      int n;
      n = 0;
      if (pct == 0) return 0;
      if ($urandom_range(3) == 0) return $urandom_range(2400);
      while (n < 40 && $urandom_range(99) < pct) n++;
      return n;
   endfunction

   function automatic word_type draw_base(word_type m);
      case ($urandom_range(5))
         0:       return word_type'($urandom_range(15));
         1:       return m * word_type'($urandom_range(1, 3));
         2:       return m - word_type'(1);
         3:       return ~word_type'($urandom_range(15));
         default: return word_type'($urandom());
      endcase
   endfunction

   function automatic word_type draw_exponent();
      case ($urandom_range(7))
         0:       return '0;
         1:       return word_type'($urandom_range(1, 64));
         2:       return word_type'(1) << $urandom_range(DATA_WIDTH - 1);
         3:       return '1;
         default: return word_type'($urandom());
      endcase
   endfunction

   task automatic send_item(input word_type base, input word_type exponent);
      int gap;
      gap = draw_gap(idle_pct);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start        <= 1'b1;
      req_base     <= base;
      req_exponent <= exponent;
      do @(posedge clock); while (!(start && !busy));
      powers.note_request(base, exponent);
   endtask

   task automatic wait_drained();
      while (powers.pending() != 0) @(posedge clock);
   endtask

   task automatic end_burst();
      start <= 1'b0;
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_modulus(input word_type value);
      csr_valid   <= 1'b1;
      csr_modulus <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      powers.modulus = value;
   endtask

   initial begin
      powers = new();
      reset        <= 1'b1;
      start        <= 1'b0;
      req_base     <= '0;
      req_exponent <= '0;
      csr_valid    <= 1'b0;
      csr_modulus  <= '0;
      idle_pct     = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // modulus still at its reset value
      send_item(32'd7, 32'd3);
      send_item(32'd6, 32'd1);
      send_item('1, '0);

      end_burst();
      write_modulus('1);
      send_item('0, '0);
      send_item('1, '1);               // base equal to modulus reduces to zero
      send_item('0, '1);
      send_item(32'd1, '1);
      send_item(32'hFFFF_FFFE, 32'd2);
      send_item(32'h1234_5678, 32'h8000_0000);
      send_item(32'd2, 32'd32);
      send_item(32'hDEAD_BEEF, 32'd1);

      // modulus of zero or one behaves as two
      end_burst();
      write_modulus('0);
      send_item(32'd3, 32'd5);
      send_item(32'd4, 32'd3);
      end_burst();
      write_modulus(32'd1);
      send_item(32'd5, 32'd7);
      send_item('0, '0);

      end_burst();
      write_modulus(32'd7);
      send_item(32'd100, '1);
      send_item(32'd7, 32'd5);
      send_item(32'd15, 32'd2);

      // prime modulus: (p-1)^(p-1) and 2^(p-1) both give one
      end_burst();
      write_modulus(32'hFFFF_FFFB);
      send_item(32'hFFFF_FFFA, 32'hFFFF_FFFA);
      send_item(32'd2, 32'hFFFF_FFFA);

      for (int p = 0; p < PHASE_COUNT; p++) begin
         word_type m;
         case (p)
            0:       m = word_type'($urandom()) | 32'h8000_0000;
            1:       m = 32'hFFFF_FFFB;
            2:       m = word_type'($urandom_range(3, 1000));
            3:       m = word_type'($urandom());
            4:       m = word_type'($urandom_range(2, 65535));
            default: m = '1;
         endcase
         end_burst();
         write_modulus(m);
         case (p % 3)
            0:       idle_pct = 0;
            1:       idle_pct = SENDER_IDLE_PCT;
            default: idle_pct = BOTH_IDLE_PCT;
         endcase
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            if (p == 4 && i == PHASE_ITEMS / 2) begin
               start <= 1'b0;
               wait_drained();
            end
            send_item(draw_base(m), draw_exponent());
         end
      end

      start <= 1'b0;
      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (powers.error_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

`default_nettype wire
